FILE: rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int unsigned ColsDefault = 80;
  localparam int unsigned RowsDefault = 32;

  // The queue depth must be a power of two so that its pointers wrap on their own.
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned TabStep = 8;

  localparam logic [7:0] CodeBs    = 8'd8;
  localparam logic [7:0] CodeTab   = 8'd9;
  localparam logic [7:0] CodeLf    = 8'd10;
  localparam logic [7:0] CodeCr    = 8'd13;
  localparam logic [7:0] CodeSpace = 8'd32;
  localparam logic [7:0] CodeLast  = 8'd126;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_READ,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_LF,
    OP_CR
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e    op;
    logic [6:0] code;
    logic [4:0] row;
    logic [6:0] col;
    logic       in_range;
  } tcw_item_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_front.sv
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int unsigned Cols = ColsDefault,
  parameter int unsigned Rows = RowsDefault
) (
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [4:0] read_row_i,
  input  wire logic [6:0] read_col_i,
  input  wire logic       q_full_i,
  input  wire logic       init_busy_i,
  output logic            push_o,
  output tcw_item_t       item_o
);

  tcw_op_e op;

  always_comb begin
    op = OP_NOP;
    if (kind_i) begin
      op = OP_READ;
    end else begin
      case (char_code_i)
        CodeLf:  op = OP_LF;
        CodeCr:  op = OP_CR;
        CodeBs:  op = OP_BS;
        CodeTab: op = OP_TAB;
        default: begin
          if (char_code_i inside {[CodeSpace:CodeLast]}) begin
            op = OP_PRINT;
          end
        end
      endcase
    end
  end

  assign in_ready_o = !q_full_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign item_o.op       = op;
  assign item_o.code     = char_code_i[6:0];
  assign item_o.row      = read_row_i;
  assign item_o.col      = read_col_i;
  assign item_o.in_range = (32'(read_row_i) < Rows) && (32'(read_col_i) < Cols);

endmodule

`default_nettype wire

FILE: rtl/tcw_queue.sv
`default_nettype none

module tcw_queue import tcw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  tcw_item_t      item_i,
  output logic           full_o,
  output logic           head_valid_o,
  output tcw_item_t      head_o,
  input  wire logic      pop_i
);

  localparam int unsigned QAw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  tcw_item_t        store_q [QueueDepth];
  logic [QAw-1:0]   wr_ptr_q;
  logic [QAw-1:0]   rd_ptr_q;
  logic [QAw:0]     count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QAw+1)'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - (QAw+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o       = (count_q == (QAw+1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = store_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int unsigned Cols = ColsDefault,
  parameter int unsigned Rows = RowsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        head_valid_i,
  input  tcw_item_t        head_i,
  output logic             pop_o,
  output logic             init_busy_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       cell_char_o,
  output logic [6:0]       cursor_col_o,
  output logic [4:0]       cursor_row_o,
  output logic [15:0]      scroll_count_o
);

  localparam int unsigned Cw    = $clog2(Cols);
  localparam int unsigned Rw    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned Aw    = Rw + Cw;
  localparam int unsigned Depth = Rows << Cw;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_RDATA,
    ST_SCROLL
  } state_e;

  state_e          state_q;
  logic [Cw-1:0]   col_q;
  logic [Rw-1:0]   line_q;
  logic [Rw-1:0]   top_q;
  logic [15:0]     count_q;
  logic [Aw-1:0]   cnt_q;
  logic [Rw-1:0]   scroll_row_q;
  logic            out_valid_q;
  logic [6:0]      cell_q;
  logic [6:0]      ocol_q;
  logic [4:0]      orow_q;
  logic [15:0]     ocnt_q;

  logic [6:0]      mem [Depth];
  logic [6:0]      rdata_q;

  logic            slot_free;
  logic            out_load;
  logic [Rw:0]     rd_sum;
  logic [Rw-1:0]   phys_rd;
  logic [Rw:0]     wr_sum;
  logic [Rw-1:0]   phys_wr;
  logic [Cw:0]     col_tab;
  logic [Cw:0]     col_step;
  logic [Rw:0]     line_step;
  logic [Cw:0]     col_n;
  logic [Rw:0]     line_n;
  logic            do_scroll;
  logic [Cw-1:0]   col_fin;
  logic [Rw-1:0]   line_fin;
  logic [Rw-1:0]   top_n;
  logic            chr_we;
  logic [Cw-1:0]   chr_col;
  logic [6:0]      chr_data;
  logic            mem_we;
  logic [Aw-1:0]   mem_addr;
  logic [6:0]      mem_wdata;
  logic            rd_en;
  logic [Aw-1:0]   rd_addr;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == ST_IDLE) && head_valid_i && slot_free;

  assign rd_sum  = {1'b0, top_q} + (Rw+1)'(head_i.row);
  assign phys_rd = (rd_sum >= (Rw+1)'(Rows)) ? Rw'(rd_sum - (Rw+1)'(Rows)) : rd_sum[Rw-1:0];
  assign wr_sum  = {1'b0, top_q} + {1'b0, line_q};
  assign phys_wr = (wr_sum >= (Rw+1)'(Rows)) ? Rw'(wr_sum - (Rw+1)'(Rows)) : wr_sum[Rw-1:0];

  assign col_tab = ({1'b0, col_q} + (Cw+1)'(TabStep)) & ~(Cw+1)'(TabStep - 1);

  always_comb begin
    col_step  = {1'b0, col_q};
    line_step = {1'b0, line_q};
    chr_we    = 1'b0;
    chr_col   = col_q;
    chr_data  = head_i.code;
    case (head_i.op)
      OP_LF: begin
        col_step  = '0;
        line_step = {1'b0, line_q} + (Rw+1)'(1);
      end
      OP_CR: begin
        col_step = '0;
      end
      OP_BS: begin
        if (col_q != '0) begin
          col_step = {1'b0, col_q - Cw'(1)};
          chr_we   = 1'b1;
          chr_col  = col_q - Cw'(1);
          chr_data = CodeSpace[6:0];
        end
      end
      OP_TAB: begin
        col_step = col_tab;
      end
      OP_PRINT: begin
        chr_we   = 1'b1;
        col_step = {1'b0, col_q} + (Cw+1)'(1);
      end
      default: ;
    endcase

    col_n  = col_step;
    line_n = line_step;
    if (col_step >= (Cw+1)'(Cols)) begin
      col_n  = '0;
      line_n = line_step + (Rw+1)'(1);
    end

    do_scroll = (line_n >= (Rw+1)'(Rows));
    col_fin   = col_n[Cw-1:0];
    line_fin  = do_scroll ? Rw'(Rows - 1) : line_n[Rw-1:0];
    if (!do_scroll) begin
      top_n = top_q;
    end else if (top_q == Rw'(Rows - 1)) begin
      top_n = '0;
    end else begin
      top_n = top_q + Rw'(1);
    end
  end

  assign out_load = (pop_o && ((head_i.op == OP_READ) ? !head_i.in_range : !do_scroll))
                 || (state_q == ST_RDATA)
                 || ((state_q == ST_SCROLL) && (cnt_q[Cw-1:0] == Cw'(Cols - 1)));

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (state_q)
      ST_INIT: begin
        mem_we   = 1'b1;
        mem_addr = cnt_q;
      end
      ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_addr  = {scroll_row_q, cnt_q[Cw-1:0]};
        mem_wdata = CodeSpace[6:0];
      end
      ST_IDLE: begin
        if (pop_o && chr_we) begin
          mem_we    = 1'b1;
          mem_addr  = {phys_wr, chr_col};
          mem_wdata = chr_data;
        end
      end
      default: ;
    endcase
  end

  assign rd_en   = pop_o && (head_i.op == OP_READ) && head_i.in_range;
  assign rd_addr = {phys_rd, Cw'(head_i.col)};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      col_q        <= '0;
      line_q       <= '0;
      top_q        <= '0;
      count_q      <= '0;
      cnt_q        <= '0;
      scroll_row_q <= '0;
      out_valid_q  <= 1'b0;
      cell_q       <= '0;
      ocol_q       <= '0;
      orow_q       <= '0;
      ocnt_q       <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_INIT: begin
          if (cnt_q == Aw'(Depth - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + Aw'(1);
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            if (head_i.op == OP_READ) begin
              if (head_i.in_range) begin
                state_q <= ST_RDATA;
              end else begin
                cell_q      <= '0;
                ocol_q      <= 7'(col_q);
                orow_q      <= 5'(line_q);
                ocnt_q      <= count_q;
              end
            end else begin
              col_q  <= col_fin;
              line_q <= line_fin;
              top_q  <= top_n;
              if (do_scroll) begin
                count_q      <= count_q + 16'd1;
                scroll_row_q <= top_q;
                cnt_q        <= '0;
                state_q      <= ST_SCROLL;
              end else begin
                cell_q      <= '0;
                ocol_q      <= 7'(col_fin);
                orow_q      <= 5'(line_fin);
                ocnt_q      <= count_q;
              end
            end
          end
        end
        ST_RDATA: begin
          cell_q      <= rdata_q;
          ocol_q      <= 7'(col_q);
          orow_q      <= 5'(line_q);
          ocnt_q      <= count_q;
          state_q     <= ST_IDLE;
        end
        ST_SCROLL: begin
          if (cnt_q[Cw-1:0] == Cw'(Cols - 1)) begin
            cnt_q       <= '0;
            cell_q      <= '0;
            ocol_q      <= 7'(col_q);
            orow_q      <= 5'(line_q);
            ocnt_q      <= count_q;
            state_q     <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + Aw'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign init_busy_o    = (state_q == ST_INIT);
  assign out_valid_o    = out_valid_q;
  assign cell_char_o    = cell_q;
  assign cursor_col_o   = ocol_q;
  assign cursor_row_o   = orow_q;
  assign scroll_count_o = ocnt_q;

endmodule

`default_nettype wire

FILE: rtl/text_console_cell_writer.sv
// Beats are queued and run at the queue head; a read first passes the registered
// memory read, and a put that scrolls waits for the sweep that blanks the new bottom
// row. One put per cycle while the output is taken and no sweep runs; a read holds the
// next item until its data is registered. A two-entry queue decouples input from
// execution. After reset, with in_ready_o low, the memory is cleared one cell a cycle,
// all Rows * 2**clog2(Cols) cells (4096 by default); cursor and counters reset to zero.
`default_nettype none

module text_console_cell_writer import tcw_pkg::*; #(
  parameter int unsigned Cols = ColsDefault,
  parameter int unsigned Rows = RowsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [4:0]  read_row_i,
  input  wire logic [6:0]  read_col_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       cell_char_o,
  output logic [6:0]       cursor_col_o,
  output logic [4:0]       cursor_row_o,
  output logic [15:0]      scroll_count_o
);

  logic      push;
  tcw_item_t item;
  logic      q_full;
  logic      head_valid;
  tcw_item_t head;
  logic      pop;
  logic      init_busy;

  tcw_front #(
    .Cols (Cols),
    .Rows (Rows)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .item_o      (item)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  tcw_back #(
    .Cols (Cols),
    .Rows (Rows)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .init_busy_o    (init_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_char_o    (cell_char_o),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .scroll_count_o (scroll_count_o)
  );

endmodule

`default_nettype wire
